// File: sv/periodic_task_release_table_assert.svh
// Assertion macros for the periodic task release table.
`ifndef PERIODIC_TASK_RELEASE_TABLE_ASSERT_SVH
`define PERIODIC_TASK_RELEASE_TABLE_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled during reset
`define PTRT_ASSERT_IMPLIES(lbl, clk, rst, pre, post) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("ptrt assertion failed");
// Next-cycle implication, disabled during reset
`define PTRT_ASSERT_NEXT(lbl, clk, rst, pre, post) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("ptrt assertion failed");
`else
`define PTRT_ASSERT_IMPLIES(lbl, clk, rst, pre, post)
`define PTRT_ASSERT_NEXT(lbl, clk, rst, pre, post)
`endif
`endif

// File: sv/ptrt_pkg.sv
// Shared types and constants of the periodic task release table.
package ptrt_pkg;

   localparam int MAX_TASKS    = 8;
   localparam int RESULT_LIMIT = 8;
   localparam int IDX_W  = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
   localparam int CNT_W  = $clog2(MAX_TASKS + 1);
   localparam int NUM_W  = $clog2(RESULT_LIMIT + 1);
   localparam int SLOT_W = 4;

   typedef enum logic [1:0] {
      OP_ADD      = 2'd0,
      OP_DELETE   = 2'd1,
      OP_TICK     = 2'd2,
      OP_DISPATCH = 2'd3
   } ptrt_op_type;

   localparam logic [2:0] RS_DONE    = 3'd0;
   localparam logic [2:0] RS_DUE     = 3'd1;
   localparam logic [2:0] RS_FULL    = 3'd2;
   localparam logic [2:0] RS_BADSLOT = 3'd3;
   localparam logic [2:0] RS_NONE    = 3'd4;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FINISH
   } ptrt_state_type;

   // Controller to datapath
   typedef struct packed {
      logic load;
      logic advance;
      logic write_add;
      logic tick_slot;
      logic take;
      logic push_mid;
      logic push_final;
   } ptrt_cmd_type;

   // Datapath to controller
   typedef struct packed {
      ptrt_op_type op;
      logic        scan_end;
      logic        cur_valid;
      logic        cur_due;
      logic        held_valid;
      logic        limit_reached;
      logic        out_free;
   } ptrt_stat_type;

endpackage

// File: sv/ptrt_ctrl.sv
// Sequencer that walks the slot table for each transaction.
module ptrt_ctrl
   import ptrt_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   input  ptrt_stat_type stat,
   output ptrt_cmd_type  cmd
);

   ptrt_state_type state_ff, state_in;

   // Hold state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Compute next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (stat.op == OP_DELETE || stat.scan_end) begin
               state_in = ST_FINISH;
            end else if (stat.op == OP_ADD && !stat.cur_valid) begin
               state_in = ST_FINISH;
            end else if (stat.op == OP_DISPATCH && stat.limit_reached) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (stat.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Drive datapath commands
   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            cmd.load  = req_valid;
         end
         ST_SCAN: begin
            if (stat.op != OP_DELETE && !stat.scan_end) begin
               case (stat.op)
                  OP_ADD: begin
                     if (!stat.cur_valid) begin
                        cmd.write_add = 1'b1;
                     end else begin
                        cmd.advance = 1'b1;
                     end
                  end
                  OP_TICK: begin
                     cmd.tick_slot = 1'b1;
                     cmd.advance   = 1'b1;
                  end
                  OP_DISPATCH: begin
                     if (!stat.limit_reached) begin
                        if (!stat.cur_due) begin
                           cmd.advance = 1'b1;
                        end else if (!stat.held_valid || stat.out_free) begin
                           // flush the previous due slot, take this one
                           cmd.push_mid = stat.held_valid;
                           cmd.take     = 1'b1;
                           cmd.advance  = 1'b1;
                        end
                     end
                  end
                  default: cmd.advance = 1'b1;
               endcase
            end
         end
         ST_FINISH: begin
            cmd.push_final = stat.out_free;
         end
         default: req_stall = 1'b1;
      endcase
   end

endmodule

// File: sv/ptrt_datapath.sv
// Slot table, scan pointer, held result and output register.
module ptrt_datapath
   import ptrt_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  ptrt_cmd_type  cmd,
   output ptrt_stat_type stat,
   input  logic [1:0]    req_command,
   input  logic [7:0]    req_task_tag,
   input  logic [15:0]   req_first_delay,
   input  logic [15:0]   req_repeat_period,
   input  logic [3:0]    req_slot_number,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   output logic [2:0]    rsp_status,
   output logic [3:0]    rsp_slot_index,
   output logic [7:0]    rsp_due_tag,
   output logic          rsp_last_result
);

   // Slot table
   logic        valid_ff   [MAX_TASKS];
   logic        valid_in   [MAX_TASKS];
   logic [7:0]  tag_ff     [MAX_TASKS];
   logic [7:0]  tag_in     [MAX_TASKS];
   logic [15:0] delay_ff   [MAX_TASKS];
   logic [15:0] delay_in   [MAX_TASKS];
   logic [15:0] period_ff  [MAX_TASKS];
   logic [15:0] period_in  [MAX_TASKS];
   logic [7:0]  pending_ff [MAX_TASKS];
   logic [7:0]  pending_in [MAX_TASKS];

   // Latched transaction
   ptrt_op_type op_ff, op_in;
   logic [7:0]  op_tag_ff, op_tag_in;
   logic [15:0] op_delay_ff, op_delay_in;
   logic [15:0] op_period_ff, op_period_in;
   logic [3:0]  op_slot_ff, op_slot_in;

   // Scan and held result
   logic [CNT_W-1:0] idx_ff, idx_in;
   logic [NUM_W-1:0] num_ff, num_in;
   logic             held_valid_ff, held_valid_in;
   logic [IDX_W-1:0] held_idx_ff, held_idx_in;
   logic [7:0]       held_tag_ff, held_tag_in;

   // Output register
   logic       out_valid_ff, out_valid_in;
   logic [2:0] out_status_ff, out_status_in;
   logic [3:0] out_slot_ff, out_slot_in;
   logic [7:0] out_tag_ff, out_tag_in;
   logic       out_last_ff, out_last_in;

   logic [IDX_W-1:0] cur;
   logic             scan_end;
   logic             cur_valid;
   logic             del_in_range;
   logic [IDX_W-1:0] del_idx;

   assign cur          = idx_ff[IDX_W-1:0];
   assign scan_end     = (idx_ff == CNT_W'(MAX_TASKS));
   assign cur_valid    = !scan_end && valid_ff[cur];
   assign del_in_range = ({1'b0, op_slot_ff} < 5'(MAX_TASKS));
   assign del_idx      = op_slot_ff[IDX_W-1:0];

   // Report status to the controller
   always_comb begin
      stat.op            = op_ff;
      stat.scan_end      = scan_end;
      stat.cur_valid     = cur_valid;
      stat.cur_due       = cur_valid && (pending_ff[cur] != 8'd0);
      stat.held_valid    = held_valid_ff;
      stat.limit_reached = (num_ff == NUM_W'(RESULT_LIMIT));
      stat.out_free      = !out_valid_ff || !rsp_stall;
   end

   // Update the slot table
   always_comb begin
      valid_in   = valid_ff;
      tag_in     = tag_ff;
      delay_in   = delay_ff;
      period_in  = period_ff;
      pending_in = pending_ff;
      if (cmd.write_add) begin
         valid_in[cur]   = 1'b1;
         tag_in[cur]     = op_tag_ff;
         delay_in[cur]   = op_delay_ff;
         period_in[cur]  = op_period_ff;
         pending_in[cur] = 8'd0;
      end
      if (cmd.tick_slot && cur_valid) begin
         if (delay_ff[cur] == 16'd0) begin
            if (pending_ff[cur] != 8'hFF) begin
               pending_in[cur] = pending_ff[cur] + 8'd1;
            end
            if (period_ff[cur] != 16'd0) begin
               delay_in[cur] = period_ff[cur] - 16'd1;
            end
         end else begin
            delay_in[cur] = delay_ff[cur] - 16'd1;
         end
      end
      if (cmd.take) begin
         pending_in[cur] = pending_ff[cur] - 8'd1;
         if (period_ff[cur] == 16'd0) begin
            valid_in[cur] = 1'b0;
         end
      end
      if (cmd.push_final && op_ff == OP_DELETE && del_in_range) begin
         valid_in[del_idx] = 1'b0;
      end
   end

   // Latch transaction, advance scan, track held result
   always_comb begin
      op_in         = op_ff;
      op_tag_in     = op_tag_ff;
      op_delay_in   = op_delay_ff;
      op_period_in  = op_period_ff;
      op_slot_in    = op_slot_ff;
      idx_in        = idx_ff;
      num_in        = num_ff;
      held_valid_in = held_valid_ff;
      held_idx_in   = held_idx_ff;
      held_tag_in   = held_tag_ff;
      if (cmd.load) begin
         op_in         = ptrt_op_type'(req_command);
         op_tag_in     = req_task_tag;
         op_delay_in   = req_first_delay;
         op_period_in  = req_repeat_period;
         op_slot_in    = req_slot_number;
         idx_in        = '0;
         num_in        = '0;
         held_valid_in = 1'b0;
      end
      if (cmd.advance) begin
         idx_in = idx_ff + CNT_W'(1);
      end
      if (cmd.write_add) begin
         held_valid_in = 1'b1;
         held_idx_in   = cur;
         held_tag_in   = 8'd0;
      end
      if (cmd.take) begin
         held_valid_in = 1'b1;
         held_idx_in   = cur;
         held_tag_in   = tag_ff[cur];
         num_in        = num_ff + NUM_W'(1);
      end
   end

   // Load the output register
   always_comb begin
      out_valid_in  = out_valid_ff && rsp_stall;
      out_status_in = out_status_ff;
      out_slot_in   = out_slot_ff;
      out_tag_in    = out_tag_ff;
      out_last_in   = out_last_ff;
      if (cmd.push_mid) begin
         out_valid_in  = 1'b1;
         out_status_in = RS_DUE;
         out_slot_in   = SLOT_W'(held_idx_ff);
         out_tag_in    = held_tag_ff;
         out_last_in   = 1'b0;
      end
      if (cmd.push_final) begin
         out_valid_in  = 1'b1;
         out_last_in   = 1'b1;
         out_status_in = RS_DONE;
         out_slot_in   = '0;
         out_tag_in    = '0;
         case (op_ff)
            OP_ADD: begin
               if (held_valid_ff) begin
                  out_slot_in = SLOT_W'(held_idx_ff);
               end else begin
                  out_status_in = RS_FULL;
               end
            end
            OP_DELETE: begin
               if (!del_in_range) begin
                  out_status_in = RS_BADSLOT;
               end
            end
            OP_TICK: out_status_in = RS_DONE;
            OP_DISPATCH: begin
               if (held_valid_ff) begin
                  out_status_in = RS_DUE;
                  out_slot_in   = SLOT_W'(held_idx_ff);
                  out_tag_in    = held_tag_ff;
               end else begin
                  out_status_in = RS_NONE;
               end
            end
            default: out_status_in = RS_DONE;
         endcase
      end
   end

   // Hold registers
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff      <= '{default: 1'b0};
         held_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
         op_ff         <= OP_ADD;
         idx_ff        <= '0;
         num_ff        <= '0;
      end else begin
         valid_ff      <= valid_in;
         held_valid_ff <= held_valid_in;
         out_valid_ff  <= out_valid_in;
         op_ff         <= op_in;
         idx_ff        <= idx_in;
         num_ff        <= num_in;
      end
   end

   always_ff @(posedge clock) begin
      tag_ff        <= tag_in;
      delay_ff      <= delay_in;
      period_ff     <= period_in;
      pending_ff    <= pending_in;
      op_tag_ff     <= op_tag_in;
      op_delay_ff   <= op_delay_in;
      op_period_ff  <= op_period_in;
      op_slot_ff    <= op_slot_in;
      held_idx_ff   <= held_idx_in;
      held_tag_ff   <= held_tag_in;
      out_status_ff <= out_status_in;
      out_slot_ff   <= out_slot_in;
      out_tag_ff    <= out_tag_in;
      out_last_ff   <= out_last_in;
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_status      = out_status_ff;
   assign rsp_slot_index  = out_slot_ff;
   assign rsp_due_tag     = out_tag_ff;
   assign rsp_last_result = out_last_ff;

endmodule

// File: sv/periodic_task_release_table.sv
// Add, tick and dispatch walk the table one slot per cycle; an add stops at the first
// free slot, and delete skips the walk. A result is registered in the finish state, or
// mid-walk when a dispatch flushes a held due slot; a stalled result channel holds the
// dispatch walk and the finish state.
// Reset clears the valid marks and the controller, with no clearing pass.
`include "periodic_task_release_table_assert.svh"

module periodic_task_release_table
   import ptrt_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_command,
   input  logic [7:0]  req_task_tag,
   input  logic [15:0] req_first_delay,
   input  logic [15:0] req_repeat_period,
   input  logic [3:0]  req_slot_number,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_status,
   output logic [3:0]  rsp_slot_index,
   output logic [7:0]  rsp_due_tag,
   output logic        rsp_last_result
);

   ptrt_cmd_type  cmd;
   ptrt_stat_type stat;

   // Sequence the slot walk
   ptrt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   // Hold the table and the results
   ptrt_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .stat              (stat),
      .req_command       (req_command),
      .req_task_tag      (req_task_tag),
      .req_first_delay   (req_first_delay),
      .req_repeat_period (req_repeat_period),
      .req_slot_number   (req_slot_number),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_status        (rsp_status),
      .rsp_slot_index    (rsp_slot_index),
      .rsp_due_tag       (rsp_due_tag),
      .rsp_last_result   (rsp_last_result)
   );

   // Never overwrite a result that is still waiting
   `PTRT_ASSERT_IMPLIES(a_push_when_free, clock, reset, cmd.push_mid || cmd.push_final, stat.out_free)
   // Block goes busy right after accepting a transaction
   `PTRT_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && !req_stall, req_stall)
   // Only a held due slot gets flushed mid-dispatch
   `PTRT_ASSERT_IMPLIES(a_mid_has_held, clock, reset, cmd.push_mid, stat.held_valid && !cmd.push_final)

endmodule

// File: tb/tb_top.sv
// Self-checking testbench for the periodic task release table with a transaction scoreboard.
module tb_top
   import ptrt_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int IDLE_LIMIT   = 4000;
   localparam int HOLD_CYCLES  = 400;
   localparam int RANDOM_ITEMS = 170;
   localparam int HOLD_START   = 40;
   localparam int CALM_FIRST   = 80;
   localparam int CALM_LAST    = 140;
   localparam int SAT_TICKS    = 258;
   localparam int DRAIN_CYCLES = 40;
   localparam int MAX_REPORTS  = 10;

   typedef struct packed {
      logic [2:0] status;
      logic [3:0] slot_index;
      logic [7:0] due_tag;
      logic       last_result;
   } task_release_type;

   // Shadow copy of the task table and the queue of releases it predicts
   class release_scoreboard_type;
      bit               slot_valid   [MAX_TASKS];
      bit [7:0]         slot_tag     [MAX_TASKS];
      bit [15:0]        slot_delay   [MAX_TASKS];
      bit [15:0]        slot_period  [MAX_TASKS];
      bit [7:0]         slot_pending [MAX_TASKS];
      task_release_type release_q[$];
      int               mismatch_count;

      function void clear_slot(int s);
         slot_valid[s]   = 1'b0;
         slot_tag[s]     = '0;
         slot_delay[s]   = '0;
         slot_period[s]  = '0;
         slot_pending[s] = '0;
      endfunction

      function void expect_release(logic [2:0] status, int slot, logic [7:0] tag,
                                   logic last);
         task_release_type r;
         r.status      = status;
         r.slot_index  = 4'(slot);
         r.due_tag     = tag;
         r.last_result = last;
         release_q.push_back(r);
      endfunction

      function void log_failure(string what, task_release_type exp_r,
                                task_release_type got_r);
         mismatch_count++;
         if (mismatch_count <= MAX_REPORTS) begin
            $write("%0t %s: expected status=%0d slot=%0d tag=%0d last=%0d,",
                   $realtime, what, exp_r.status, exp_r.slot_index, exp_r.due_tag,
                   exp_r.last_result);
            $display(" got status=%0d slot=%0d tag=%0d last=%0d", got_r.status,
                     got_r.slot_index, got_r.due_tag, got_r.last_result);
         end
      endfunction

      // Update the shadow table for one accepted request and queue its releases
      function void note_request(ptrt_op_type op, bit [7:0] tag, bit [15:0] dly,
                                 bit [15:0] per, bit [3:0] slot_num);
         int s;
         int free_slot;
         int emitted;
         free_slot = -1;
         emitted   = 0;
         case (op)
            OP_ADD: begin
               for (s = 0; s < MAX_TASKS; s++)
                  if (!slot_valid[s] && free_slot < 0) free_slot = s;
               if (free_slot >= 0) begin
                  slot_valid[free_slot]   = 1'b1;
                  slot_tag[free_slot]     = tag;
                  slot_delay[free_slot]   = dly;
                  slot_period[free_slot]  = per;
                  slot_pending[free_slot] = '0;
                  expect_release(RS_DONE, free_slot, 8'h00, 1'b1);
               end else begin
                  expect_release(RS_FULL, 0, 8'h00, 1'b1);
               end
            end
            OP_DELETE: begin
               if (slot_num < MAX_TASKS) begin
                  clear_slot(slot_num);
                  expect_release(RS_DONE, 0, 8'h00, 1'b1);
               end else begin
                  expect_release(RS_BADSLOT, 0, 8'h00, 1'b1);
               end
            end
            OP_TICK: begin
               for (s = 0; s < MAX_TASKS; s++) begin
                  if (slot_valid[s]) begin
                     if (slot_delay[s] == 16'd0) begin
                        if (slot_pending[s] != 8'hFF) slot_pending[s]++;
                        if (slot_period[s] != 16'd0) slot_delay[s] = slot_period[s] - 16'd1;
                     end else begin
                        slot_delay[s]--;
                     end
                  end
               end
               expect_release(RS_DONE, 0, 8'h00, 1'b1);
            end
            default: begin
               for (s = 0; s < MAX_TASKS && emitted < RESULT_LIMIT; s++) begin
                  if (slot_valid[s] && slot_pending[s] != 8'd0) begin
                     expect_release(RS_DUE, s, slot_tag[s], 1'b0);
                     emitted++;
                     slot_pending[s]--;
                     if (slot_period[s] == 16'd0) clear_slot(s);
                  end
               end
               if (emitted == 0) expect_release(RS_NONE, 0, 8'h00, 1'b1);
               else release_q[$].last_result = 1'b1;
            end
         endcase
      endfunction

      // Compare one accepted response with the oldest predicted release
      function void check_response(task_release_type got_r);
         task_release_type exp_r;
         if (release_q.size() == 0) begin
            log_failure("unexpected response", '0, got_r);
         end else begin
            exp_r = release_q.pop_front();
            if (got_r !== exp_r) log_failure("response mismatch", exp_r, got_r);
         end
      endfunction

      function void check_drained();
         while (release_q.size() != 0)
            log_failure("missing response", release_q.pop_front(), 'x);
      endfunction
   endclass

   logic        clock             = 1'b0;
   logic        reset             = 1'b1;
   logic        req_valid         = 1'b0;
   logic        req_stall;
   logic [1:0]  req_command       = OP_TICK;
   logic [7:0]  req_task_tag      = '0;
   logic [15:0] req_first_delay   = '0;
   logic [15:0] req_repeat_period = '0;
   logic [3:0]  req_slot_number   = '0;
   logic        rsp_valid;
   logic        rsp_stall         = 1'b0;
   logic [2:0]  rsp_status;
   logic [3:0]  rsp_slot_index;
   logic [7:0]  rsp_due_tag;
   logic        rsp_last_result;

   logic        calm              = 1'b0;
   logic        hold_off          = 1'b0;
   int          random_sent       = 0;

   release_scoreboard_type sb = new();

   periodic_task_release_table u_top (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_command       (req_command),
      .req_task_tag      (req_task_tag),
      .req_first_delay   (req_first_delay),
      .req_repeat_period (req_repeat_period),
      .req_slot_number   (req_slot_number),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_status        (rsp_status),
      .rsp_slot_index    (rsp_slot_index),
      .rsp_due_tag       (rsp_due_tag),
      .rsp_last_result   (rsp_last_result)
   );

   // Generate the clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Offer one request transaction, idle at random first, hold it until accepted
   task automatic send_item(input ptrt_op_type op, input logic [7:0] tag,
                            input logic [15:0] dly, input logic [15:0] per,
                            input logic [3:0] slot);
      while (!calm && $urandom_range(0, 99) < 15) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_command       <= op;
      req_task_tag      <= tag;
      req_first_delay   <= dly;
      req_repeat_period <= per;
      req_slot_number   <= slot;
      do @(posedge clock); while (req_stall);
      sb.note_request(op, tag, dly, per, slot);
   endtask

   // Mostly well-formed commands with short timers, some fully random noise
   task automatic send_random();
      ptrt_op_type op;
      logic [7:0]  tag;
      logic [15:0] dly;
      logic [15:0] per;
      logic [3:0]  slot;
      int          pick;
      pick = $urandom_range(0, 99);
      tag  = 8'($urandom_range(0, 255));
      dly  = 16'($urandom);
      per  = 16'($urandom);
      slot = 4'($urandom_range(0, 15));
      if (pick < 10) begin
         op = ptrt_op_type'($urandom_range(0, 3));
      end else begin
         if (pick < 35) op = OP_ADD;
         else if (pick < 47) op = OP_DELETE;
         else if (pick < 75) op = OP_TICK;
         else op = OP_DISPATCH;
         if ($urandom_range(0, 9) != 0) begin
            dly = 16'($urandom_range(0, 6));
            per = ($urandom_range(0, 2) == 0) ? 16'd0 : 16'($urandom_range(1, 6));
         end
         if (op == OP_DELETE && $urandom_range(0, 2) != 0)
            slot = 4'($urandom_range(0, MAX_TASKS - 1));
      end
      send_item(op, tag, dly, per, slot);
   endtask

   // Check accepted responses and drive the response stall
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_response({rsp_status, rsp_slot_index, rsp_due_tag, rsp_last_result});
      rsp_stall <= hold_off || (!calm && $urandom_range(0, 99) < 15);
   end

   // Hold off the receiver for a long stretch so the table backs up its input
   initial begin
      wait (random_sent >= HOLD_START);
      @(posedge clock);
      hold_off <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      hold_off <= 1'b0;
   end

   // End the run when no transaction moves for too long
   initial begin
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < IDLE_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles = 0;
         else idle_cycles++;
      end
      $display("[periodic_task_release_table] ERROR");
      $finish;
   end

   // Stimulus and end of run
   initial begin
      int k;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Empty table: nothing due, tick, bad and boundary slot numbers
      send_item(OP_DISPATCH, 8'h00, 16'h0000, 16'h0000, 4'd0);
      send_item(OP_TICK, 8'hFF, 16'hFFFF, 16'hFFFF, 4'hF);
      send_item(OP_DELETE, 8'h00, 16'h0000, 16'h0000, 4'd15);
      send_item(OP_DELETE, 8'h00, 16'h0000, 16'h0000, 4'(MAX_TASKS));
      send_item(OP_DELETE, 8'h00, 16'h0000, 16'h0000, 4'd0);

      // Fill the table: one-shot, extreme timers, period one, then overflow
      send_item(OP_ADD, 8'hFF, 16'h0000, 16'h0000, 4'd0);
      send_item(OP_ADD, 8'h00, 16'hFFFF, 16'hFFFF, 4'd0);
      send_item(OP_ADD, 8'hA5, 16'h0001, 16'h0001, 4'd0);
      for (k = 3; k < MAX_TASKS; k++)
         send_item(OP_ADD, 8'(8'h10 + k), 16'h0000, 16'h0002, 4'd0);
      send_item(OP_ADD, 8'h5A, 16'h0000, 16'h0000, 4'd0);

      // Release and dispatch, one-shot removal
      send_item(OP_TICK, 8'h00, 16'h0000, 16'h0000, 4'd0);
      send_item(OP_TICK, 8'h00, 16'h0000, 16'h0000, 4'd0);
      send_item(OP_DISPATCH, 8'h00, 16'h0000, 16'h0000, 4'd0);
      send_item(OP_DISPATCH, 8'h00, 16'h0000, 16'h0000, 4'd0);
      send_item(OP_TICK, 8'h00, 16'h0000, 16'h0000, 4'd0);
      send_item(OP_DISPATCH, 8'h00, 16'h0000, 16'h0000, 4'd0);

      // Delete valid slots, add reuses the lowest free one
      send_item(OP_DELETE, 8'h00, 16'h0000, 16'h0000, 4'(MAX_TASKS - 1));
      send_item(OP_DELETE, 8'h00, 16'h0000, 16'h0000, 4'd1);
      send_item(OP_ADD, 8'h3C, 16'h0000, 16'h0000, 4'd0);

      // Tick long enough to saturate the pending counts of the slots that fire every tick, then drain a little
      for (k = 0; k < SAT_TICKS; k++)
         send_item(OP_TICK, 8'($urandom), 16'($urandom), 16'($urandom), 4'($urandom));
      send_item(OP_DISPATCH, 8'h00, 16'h0000, 16'h0000, 4'd0);
      send_item(OP_DISPATCH, 8'h00, 16'h0000, 16'h0000, 4'd0);
      send_item(OP_DELETE, 8'h00, 16'h0000, 16'h0000, 4'd2);

      // Random traffic with a stretch of no idling in the middle
      for (k = 0; k < RANDOM_ITEMS; k++) begin
         calm <= (k >= CALM_FIRST && k < CALM_LAST);
         send_random();
         random_sent = k + 1;
      end
      req_valid <= 1'b0;
      calm      <= 1'b0;

      // Drain the predicted releases, then watch for stray responses
      while (sb.release_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      sb.check_drained();
      if (sb.mismatch_count == 0) begin
         $display("[periodic_task_release_table] OK");
      end else begin
         $display("[periodic_task_release_table] ERROR");
      end
      $finish;
   end

endmodule

// File: filelist.f
+incdir+sv
sv/ptrt_pkg.sv
sv/ptrt_ctrl.sv
sv/ptrt_datapath.sv
sv/periodic_task_release_table.sv
tb/tb_top.sv
